// ===== rtl/core/alis_pkg.sv =====
// Package for the bounded ordered word list: operation and status codes,
// field widths and default sizes. No dependencies.
`default_nettype none

package alis_pkg;

	// Default sizes
	localparam int CAPACITY_DEF   = 16;
	localparam int DATA_WIDTH_DEF = 32;

	// Fixed field widths of the request and result transfers
	localparam int OP_W     = 3;
	localparam int WORD_W   = 32;
	localparam int POS_W    = 4;
	localparam int COUNT_W  = 5;
	localparam int STATUS_W = 2;

	// Request operations
	typedef enum logic [OP_W-1:0] {
		OP_APPEND = 3'd0,
		OP_INSERT = 3'd1,
		OP_POP    = 3'd2,
		OP_READ   = 3'd3,
		OP_SEARCH = 3'd4
	} op_t;

	// Result status
	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2,
		ST_RANGE = 2'd3
	} status_t;

endpackage

`default_nettype wire

// ===== rtl/core/alis_cell.sv =====
// One storage cell of the list chain: holds one entry, takes the new word
// or its lower neighbor's entry on a write, and compares against a key.
// No package dependencies.
`default_nettype none

module alis_cell #(
	parameter int INDEX      = 0,
	parameter int DATA_WIDTH = 32,
	parameter int CNT_W      = 5
) (
	input  wire logic                  clk,
	input  wire logic                  wr_en,
	input  wire logic [CNT_W-1:0]      where,
	input  wire logic [CNT_W-1:0]      count,
	input  wire logic [DATA_WIDTH-1:0] wr_word,
	input  wire logic [DATA_WIDTH-1:0] left_word,
	input  wire logic [DATA_WIDTH-1:0] cmp_word,
	output logic      [DATA_WIDTH-1:0] word,
	output logic                       match
);

	localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(INDEX);

	logic [DATA_WIDTH-1:0] word_q;
	logic                  load_new;
	logic                  load_left;

	// Insert decode: this cell is the target, or sits above it and inside the list
	assign load_new  = wr_en && (where == MY_IDX);
	assign load_left = wr_en && (MY_IDX > where) && (MY_IDX <= count);

	// Entry storage, no reset needed
	always_ff @(posedge clk) begin
		if (load_new) begin
			word_q <= wr_word;
		end else if (load_left) begin
			word_q <= left_word;
		end
	end

	// Only entries below the count take part in a search
	assign word  = word_q;
	assign match = (word_q == cmp_word) && (MY_IDX < count);

endmodule

`default_nettype wire

// ===== rtl/core/alis_first_match.sv =====
// Lowest-index match finder over the cell match lines.
// No package dependencies.
`default_nettype none

module alis_first_match #(
	parameter int N     = 16,
	parameter int IDX_W = 4
) (
	input  wire logic [N-1:0]     hits,
	output logic                  any_hit,
	output logic      [IDX_W-1:0] idx
);

	logic [N-1:0] lowest;

	// Isolate the lowest set bit, then encode the resulting one-hot
	assign lowest  = hits & (~hits + N'(1));
	assign any_hit = |hits;

	always_comb begin
		idx = '0;
		for (int i = 0; i < N; i++) begin
			if (lowest[i]) begin
				idx = idx | IDX_W'(i);
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/array_list_insert_search.sv =====
// Top level of the bounded ordered word list: a chain of entry cells,
// count and status logic, and the result register. Uses alis_pkg,
// alis_cell and alis_first_match.
`default_nettype none

// Usage
//   Request channel: a transfer happens at a rising edge with start high and
//   busy low. busy is always low: a request is taken in every cycle.
//   Each request carries operation, data_word and position.
//   Result channel: exactly one result per request, shown for one cycle with
//   done high; the receiver cannot stall it, so it must take it then.
// Pipeline and throughput
//   Append and insert update the cells and the count, pop only the count, at
//   the edge that takes the request; all cells shift in parallel, so the
//   list state is ready for the next request in the following cycle.
//   Read and search go through the cell compare lines, the lowest-match
//   encoder and the read select from the stage 1 registers, and the result
//   is registered: done rises once the request has passed the stage 1
//   registers and then the result registers.
//   Throughput is one request per cycle.
// Reset
//   arst_n clears the count and the pipeline valid bits; entry words stay
//   undefined until written and are never read before that.
module array_list_insert_search #(
	parameter int CAPACITY   = alis_pkg::CAPACITY_DEF,
	parameter int DATA_WIDTH = alis_pkg::DATA_WIDTH_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           start,
	output logic                                busy,
	input  wire logic [alis_pkg::OP_W-1:0]      operation,
	input  wire logic [alis_pkg::WORD_W-1:0]    data_word,
	input  wire logic [alis_pkg::POS_W-1:0]     position,
	output logic                                done,
	output logic      [alis_pkg::WORD_W-1:0]    read_word,
	output logic                                found,
	output logic      [alis_pkg::POS_W-1:0]     found_position,
	output logic      [alis_pkg::COUNT_W-1:0]   entry_count,
	output logic      [alis_pkg::STATUS_W-1:0]  status
);

	import alis_pkg::*;

	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int IDX_W = $clog2(CAPACITY);
	localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
	localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAPACITY);

	// Request side
	logic                  accept;
	op_t                   op;
	logic [DATA_WIDTH-1:0] key;
	logic [CMP_W-1:0]      pos_ext;
	logic [CMP_W-1:0]      cnt_ext;
	logic                  full;
	logic                  wr_en;
	logic [CNT_W-1:0]      where;
	status_t               status_d;
	logic [CNT_W-1:0]      count_q;
	logic [CNT_W-1:0]      count_d;

	// Stage 1 registers
	logic                  valid_s1;
	op_t                   op_s1;
	logic [POS_W-1:0]      pos_s1;
	logic [DATA_WIDTH-1:0] key_s1;
	status_t               status_s1;

	// Cell chain
	logic [DATA_WIDTH-1:0] cell_word [CAPACITY];
	logic [CAPACITY-1:0]   cell_match;
	logic                  any_hit;
	logic [IDX_W-1:0]      hit_idx;
	logic [DATA_WIDTH-1:0] sel_word;

	// Result registers
	logic                  done_q;
	logic [WORD_W-1:0]     read_word_q;
	logic                  found_q;
	logic [POS_W-1:0]      found_pos_q;
	logic [COUNT_W-1:0]    count_out_q;
	status_t               status_q;

	assign busy    = 1'b0;
	assign accept  = start && !busy;
	assign op      = op_t'(operation);
	assign key     = DATA_WIDTH'(data_word);
	assign pos_ext = CMP_W'(position);
	assign cnt_ext = CMP_W'(count_q);
	assign full    = (count_q == CAP_C);

	// Request decode: write enable, insert point, status and next count
	always_comb begin
		wr_en    = 1'b0;
		where    = count_q;
		status_d = ST_OK;
		count_d  = count_q;
		unique case (op)
			OP_APPEND, OP_INSERT: begin
				if (full) begin
					status_d = ST_FULL;
				end else begin
					wr_en   = accept;
					count_d = count_q + CNT_W'(1);
					if (op == OP_INSERT && pos_ext <= cnt_ext) begin
						where = CNT_W'(pos_ext);
					end
				end
			end
			OP_POP: begin
				if (count_q == '0) begin
					status_d = ST_EMPTY;
				end else begin
					count_d = count_q - CNT_W'(1);
				end
			end
			OP_READ: begin
				if (pos_ext >= cnt_ext) begin
					status_d = ST_RANGE;
				end
			end
			default: begin
				status_d = ST_OK;
			end
		endcase
	end

	// Count register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (accept) begin
			count_q <= count_d;
		end
	end

	// Stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	// Stage 1 payload
	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1     <= op;
			pos_s1    <= position;
			key_s1    <= key;
			status_s1 <= status_d;
		end
	end

	// Chain of cells, each taking its lower neighbor's entry on insert
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [DATA_WIDTH-1:0] left;
		if (i == 0) begin : g_first
			assign left = key;
		end else begin : g_rest
			assign left = cell_word[i-1];
		end
		alis_cell #(
			.INDEX      (i),
			.DATA_WIDTH (DATA_WIDTH),
			.CNT_W      (CNT_W)
		) u_cell (
			.clk       (clk),
			.wr_en     (wr_en),
			.where     (where),
			.count     (count_q),
			.wr_word   (key),
			.left_word (left),
			.cmp_word  (key_s1),
			.word      (cell_word[i]),
			.match     (cell_match[i])
		);
	end

	// First matching entry for search
	alis_first_match #(
		.N     (CAPACITY),
		.IDX_W (IDX_W)
	) u_first_match (
		.hits    (cell_match),
		.any_hit (any_hit),
		.idx     (hit_idx)
	);

	// Read select: one-hot AND-OR over the cells
	always_comb begin
		sel_word = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			if (CMP_W'(pos_s1) == CMP_W'(i)) begin
				sel_word = sel_word | cell_word[i];
			end
		end
	end

	// Result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= valid_s1;
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (valid_s1) begin
			read_word_q <= '0;
			found_q     <= 1'b0;
			found_pos_q <= '0;
			if (op_s1 == OP_READ && status_s1 == ST_OK) begin
				read_word_q <= WORD_W'(sel_word);
			end
			if (op_s1 == OP_SEARCH && any_hit) begin
				found_q     <= 1'b1;
				found_pos_q <= POS_W'(hit_idx);
			end
			count_out_q <= COUNT_W'(count_q);
			status_q    <= status_s1;
		end
	end

	assign done           = done_q;
	assign read_word      = read_word_q;
	assign found          = found_q;
	assign found_position = found_pos_q;
	assign entry_count    = count_out_q;
	assign status         = status_q;

`ifndef SYNTHESIS
	// One result for every request, after the stage 1 and result registers
	a_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##2 done)
		else $error("request without result");

	// The count never passes the capacity
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CAP_C)
		else $error("count above capacity");

	// A search hit always lies inside the list
	a_hit_inside: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && any_hit) |-> (CNT_W'(hit_idx) < count_q))
		else $error("match beyond count");

	// A dropped write leaves a full list full
	a_full_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && full && (op == OP_APPEND || op == OP_INSERT)) |=> full)
		else $error("full list changed on dropped write");
`endif

endmodule

`default_nettype wire

// ===== test/tb_array_list_insert_search.sv =====
// Self-checking testbench for array_list_insert_search: directed and random requests,
// each result compared with an in-bench prediction of the list state.
// Depends on alis_pkg and the array_list_insert_search RTL.
`timescale 1ns / 100ps

module tb_array_list_insert_search;
	import alis_pkg::*;

	localparam int LIST_DEPTH   = alis_pkg::CAPACITY_DEF;
	localparam int IDLE_LIMIT   = 500;
	localparam int MAX_REPORTED = 10;

	// Predicted result of one request
	typedef struct packed {
		logic [WORD_W-1:0]   word;
		logic                hit;
		logic [POS_W-1:0]    hit_pos;
		logic [COUNT_W-1:0]  count;
		status_t             st;
	} list_result_t;

	// Phases of the random traffic
	typedef enum int {
		MIX_GROW,
		MIX_SHRINK,
		MIX_BALANCED
	} traffic_mix_t;

	logic                 clk;
	logic                 arst_n;
	logic                 start;
	logic                 busy;
	logic [OP_W-1:0]      operation;
	logic [WORD_W-1:0]    data_word;
	logic [POS_W-1:0]     position;
	logic                 done;
	logic [WORD_W-1:0]    read_word;
	logic                 found;
	logic [POS_W-1:0]     found_position;
	logic [COUNT_W-1:0]   entry_count;
	logic [STATUS_W-1:0]  status;

	// Predicted list contents and the results still to come
	logic [WORD_W-1:0] list_words [LIST_DEPTH];
	int                list_len;
	list_result_t      pending_results [$];
	int                error_count;
	int                idle_cycles;
	bit                no_gaps;

	array_list_insert_search dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.operation      (operation),
		.data_word      (data_word),
		.position       (position),
		.done           (done),
		.read_word      (read_word),
		.found          (found),
		.found_position (found_position),
		.entry_count    (entry_count),
		.status         (status)
	);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	// Apply one request to the predicted list and return its result
	function automatic list_result_t apply_request(input logic [OP_W-1:0] op,
			input logic [WORD_W-1:0] word, input logic [POS_W-1:0] pos);
		list_result_t r;
		int           k;
		int           where;
		r = '0;
		r.st = ST_OK;
		case (op)
			OP_APPEND, OP_INSERT: begin
				if (list_len >= LIST_DEPTH) begin
					r.st = ST_FULL;
				end else begin
					where = (op == OP_INSERT && int'(pos) <= list_len) ? int'(pos) : list_len;
					for (k = list_len; k > where; k--)
						list_words[k] = list_words[k-1];
					list_words[where] = word;
					list_len++;
				end
			end
			OP_POP: begin
				if (list_len == 0)
					r.st = ST_EMPTY;
				else
					list_len--;
			end
			OP_READ: begin
				if (int'(pos) < list_len)
					r.word = list_words[pos];
				else
					r.st = ST_RANGE;
			end
			OP_SEARCH: begin
				for (k = 0; k < list_len; k++) begin
					if (!r.hit && list_words[k] == word) begin
						r.hit = 1'b1;
						r.hit_pos = k[POS_W-1:0];
					end
				end
			end
			default: ;
		endcase
		r.count = list_len[COUNT_W-1:0];
		return r;
	endfunction

	// Sender gap: mostly none or short, a few long
	function automatic int pick_gap();
		int r;
		if (no_gaps)
			return 0;
		r = $urandom_range(99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// Word with extremes and a small pool so duplicates show up
	function automatic logic [WORD_W-1:0] pick_word();
		int r;
		r = $urandom_range(9);
		if (r == 0)
			return '0;
		if (r == 1)
			return '1;
		if (r < 5)
			return WORD_W'($urandom_range(7));
		return $urandom;
	endfunction

	// Search key: often a word already in the list
	function automatic logic [WORD_W-1:0] pick_key();
		if (list_len > 0 && $urandom_range(1) == 1)
			return list_words[$urandom_range(list_len - 1)];
		return pick_word();
	endfunction

	// Index: mostly inside the list, sometimes anywhere
	function automatic logic [POS_W-1:0] pick_pos();
		if (list_len > 0 && $urandom_range(4) != 0)
			return POS_W'($urandom_range(list_len - 1));
		return POS_W'($urandom_range(LIST_DEPTH - 1));
	endfunction

	function automatic logic [OP_W-1:0] pick_op(input traffic_mix_t mix);
		int r;
		r = $urandom_range(99);
		case (mix)
			MIX_GROW: begin
				if (r < 35) return OP_APPEND;
				if (r < 70) return OP_INSERT;
				if (r < 80) return OP_READ;
				if (r < 93) return OP_SEARCH;
				if (r < 97) return OP_POP;
			end
			MIX_SHRINK: begin
				if (r < 10) return OP_APPEND;
				if (r < 20) return OP_INSERT;
				if (r < 30) return OP_READ;
				if (r < 40) return OP_SEARCH;
				if (r < 95) return OP_POP;
			end
			default: begin
				if (r < 20) return OP_APPEND;
				if (r < 40) return OP_INSERT;
				if (r < 55) return OP_POP;
				if (r < 75) return OP_READ;
				if (r < 95) return OP_SEARCH;
			end
		endcase
		// codes past the last operation
		return OP_W'($urandom_range(5, 7));
	endfunction

	// One request transfer, then a random gap
	task automatic send_item(input logic [OP_W-1:0] op, input logic [WORD_W-1:0] word,
			input logic [POS_W-1:0] pos);
		int gap;
		@(negedge clk);
		start     <= 1'b1;
		operation <= op;
		data_word <= word;
		position  <= pos;
		forever begin
			@(posedge clk);
			if (!busy)
				break;
		end
		pending_results.push_back(apply_request(op, word, pos));
		gap = pick_gap();
		if (gap > 0) begin
			@(negedge clk);
			start <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	task automatic send_random(input traffic_mix_t mix);
		logic [OP_W-1:0] op;
		op = pick_op(mix);
		if (op == OP_SEARCH)
			send_item(op, pick_key(), POS_W'($urandom));
		else if (op == OP_READ)
			send_item(op, $urandom, pick_pos());
		else
			send_item(op, pick_word(), POS_W'($urandom));
	endtask

	// Hold requests until every result is back
	task automatic wait_all_results();
		@(negedge clk);
		start <= 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
	endtask

	task automatic test_empty_list();
		send_item(OP_POP, '0, '0);
		send_item(OP_READ, '1, '0);
		send_item(OP_READ, '0, '1);
		send_item(OP_SEARCH, '0, '0);
	endtask

	task automatic test_unused_codes();
		send_item(3'd5, '1, '1);
		send_item(3'd6, 32'h5A5A_5A5A, 4'd7);
		send_item(3'd7, '0, '0);
	endtask

	task automatic test_insert_and_read();
		send_item(OP_APPEND, '0, '1);
		send_item(OP_APPEND, '1, '0);
		send_item(OP_INSERT, 32'hA5A5_A5A5, 4'd0);
		// index past the end lands at the tail
		send_item(OP_INSERT, 32'd1, 4'd15);
		send_item(OP_INSERT, 32'h1234_5678, 4'd2);
		// index equal to the count also lands at the tail
		send_item(OP_INSERT, 32'd1, 4'd5);
		send_item(OP_READ, '0, 4'd0);
		send_item(OP_READ, '0, 4'd5);
		send_item(OP_READ, '0, 4'd6);
	endtask

	task automatic test_search();
		send_item(OP_SEARCH, '1, '0);
		// duplicate word: first match wins
		send_item(OP_SEARCH, 32'd1, '1);
		send_item(OP_SEARCH, '0, '0);
		send_item(OP_SEARCH, 32'hDEAD_BEEF, '0);
		send_item(OP_POP, '0, '0);
	endtask

	task automatic test_fill_and_drain();
		while (list_len < LIST_DEPTH)
			send_item($urandom_range(1) ? OP_INSERT : OP_APPEND, pick_word(), POS_W'($urandom));
		send_item(OP_APPEND, '1, '0);
		send_item(OP_INSERT, '0, '0);
		send_item(OP_READ, '0, 4'd15);
		send_item(OP_SEARCH, list_words[LIST_DEPTH-1], '0);
		while (list_len > 0)
			send_item(OP_POP, $urandom, POS_W'($urandom));
		send_item(OP_POP, '0, '0);
	endtask

	task automatic test_pause_for_results();
		repeat (10) send_random(MIX_GROW);
		wait_all_results();
		repeat (10) send_random(MIX_BALANCED);
	endtask

	task automatic test_random_traffic(input int rounds);
		int n;
		for (n = 0; n < rounds; n++) begin
			no_gaps = ($urandom_range(3) == 0);
			repeat (28) send_random(MIX_GROW);
			no_gaps = ($urandom_range(3) == 0);
			repeat (22) send_random(MIX_BALANCED);
			no_gaps = ($urandom_range(3) == 0);
			repeat (28) send_random(MIX_SHRINK);
		end
		no_gaps = 1'b0;
	endtask

	// Result check against the oldest prediction
	always @(posedge clk) begin
		list_result_t want;
		if (arst_n && done === 1'b1) begin
			if (pending_results.size() == 0) begin
				error_count++;
				if (error_count <= MAX_REPORTED)
					$display("unexpected result: word=%h found=%b pos=%0d count=%0d status=%0d",
						read_word, found, found_position, entry_count, status);
			end else begin
				want = pending_results.pop_front();
				if (read_word !== want.word || found !== want.hit ||
						found_position !== want.hit_pos || entry_count !== want.count ||
						status !== want.st) begin
					error_count++;
					if (error_count <= MAX_REPORTED)
						$display("mismatch: expected word=%h found=%b pos=%0d count=%0d status=%0d, got word=%h found=%b pos=%0d count=%0d status=%0d",
							want.word, want.hit, want.hit_pos, want.count, want.st,
							read_word, found, found_position, entry_count, status);
				end
			end
		end
	end

	// Watchdog on cycles with no transfer on either side
	always @(posedge clk) begin
		if ((start && !busy) || done)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("[array_list_insert_search] ERROR");
			$finish;
		end
	end

	initial begin
		arst_n      = 1'b0;
		start       = 1'b0;
		operation   = '0;
		data_word   = '0;
		position    = '0;
		list_len    = 0;
		error_count = 0;
		idle_cycles = 0;
		no_gaps     = 1'b0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_empty_list();
		test_unused_codes();
		test_insert_and_read();
		test_search();
		test_fill_and_drain();
		test_pause_for_results();
		test_random_traffic(10);

		// drain: all results back, then a wait for stray results before the verdict
		wait_all_results();
		repeat (6) @(posedge clk);
		if (error_count == 0 && pending_results.size() == 0)
			$display("[array_list_insert_search] OK");
		else
			$display("[array_list_insert_search] ERROR");
		$finish;
	end

endmodule
